// File: design/tcw_pkg.sv
// tcw_pkg: shared types and constants for the text console writer
// operation codes, character codes, register indexes, queue entry and config structs
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 12;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // operation codes on in_op
  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_MOVE  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CARET   = 8'd94;
  localparam logic [CHAR_W-1:0] CH_W       = 8'd119;
  localparam logic [CHAR_W-1:0] CH_R       = 8'd114;
  localparam logic [CHAR_W-1:0] CH_P       = 8'd112;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  // configuration register indexes
  localparam logic [1:0] CFG_WHITE = 2'd0;
  localparam logic [1:0] CFG_RED   = 2'd1;
  localparam logic [1:0] CFG_PINK  = 2'd2;

  localparam logic [ATTR_W-1:0] ATTR_WHITE_RST = 8'd15;
  localparam logic [ATTR_W-1:0] ATTR_RED_RST   = 8'd12;
  localparam logic [ATTR_W-1:0] ATTR_PINK_RST  = 8'd13;

  typedef enum logic [2:0] {
    K_PUT,
    K_SET,
    K_MOVE,
    K_READ,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  char_code;
    logic signed [7:0]  x_value;
    logic signed [7:0]  y_value;
    logic               is_nl;
    logic               is_caret;
    logic               is_w;
    logic               is_r;
    logic               is_p;
    logic               rd_ok;
    logic [POS_W-1:0]   rd_addr;
  } q_entry_t;

  typedef struct packed {
    logic [ATTR_W-1:0] white;
    logic [ATTR_W-1:0] red;
    logic [ATTR_W-1:0] pink;
  } attr_cfg_t;

endpackage

// File: design/tcw_ram.sv
// tcw_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/tcw_front.sv
// tcw_front: accepts input words, decodes the operation and classifies the character
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_op,
  input  logic [tcw_pkg::CHAR_W-1:0] in_char_code,
  input  logic signed [7:0]        in_x_value,
  input  logic signed [7:0]        in_y_value,
  input  logic                     init_busy,
  input  logic                     q_full,
  output logic                     q_push,
  output tcw_pkg::q_entry_t        q_entry
);

  localparam logic [tcw_pkg::POS_W-1:0] COLS_P = tcw_pkg::POS_W'(COLS);
  localparam logic [7:0]                COLS_8 = 8'(COLS);
  localparam logic [7:0]                ROWS_8 = 8'(ROWS);

  logic x_ok;
  logic y_ok;

  assign in_stall = q_full | init_busy;
  assign q_push   = in_valid & ~in_stall;

  // read address only matters when the cell is on screen
  assign x_ok = ~in_x_value[7] && ({1'b0, in_x_value[6:0]} < COLS_8);
  assign y_ok = ~in_y_value[7] && ({1'b0, in_y_value[6:0]} < ROWS_8);

  always_comb begin
    q_entry.char_code = in_char_code;
    q_entry.x_value   = in_x_value;
    q_entry.y_value   = in_y_value;
    q_entry.is_nl     = (in_char_code == tcw_pkg::CH_NEWLINE);
    q_entry.is_caret  = (in_char_code == tcw_pkg::CH_CARET);
    q_entry.is_w      = (in_char_code == tcw_pkg::CH_W);
    q_entry.is_r      = (in_char_code == tcw_pkg::CH_R);
    q_entry.is_p      = (in_char_code == tcw_pkg::CH_P);
    q_entry.rd_ok     = x_ok & y_ok;
    q_entry.rd_addr   = tcw_pkg::POS_W'(in_y_value[4:0]) * COLS_P
                      + tcw_pkg::POS_W'(in_x_value[6:0]);
    unique case (in_op)
      tcw_pkg::OP_PUT:   q_entry.kind = tcw_pkg::K_PUT;
      tcw_pkg::OP_SET:   q_entry.kind = tcw_pkg::K_SET;
      tcw_pkg::OP_MOVE:  q_entry.kind = tcw_pkg::K_MOVE;
      tcw_pkg::OP_READ:  q_entry.kind = tcw_pkg::K_READ;
      tcw_pkg::OP_CLEAR: q_entry.kind = tcw_pkg::K_CLEAR;
      default:           q_entry.kind = tcw_pkg::K_NOP;
    endcase
  end

endmodule

// File: design/tcw_queue.sv
// tcw_queue: two-entry queue of decoded words between front and back
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcw_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tcw_pkg::q_entry_t head_entry
);

  tcw_pkg::q_entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: design/tcw_back.sv
// tcw_back: executes decoded words against cursor, attribute and screen store
// depends on tcw_pkg and tcw_ram
`timescale 1ns / 1ps

module tcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcw_pkg::attr_cfg_t         cfg,
  input  logic                       q_valid,
  input  tcw_pkg::q_entry_t          q_entry,
  output logic                       q_pop,
  output logic                       init_busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tcw_pkg::COL_W-1:0]  out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [tcw_pkg::POS_W-1:0]  out_cursor_pos,
  output logic [tcw_pkg::ATTR_W-1:0] out_current_attr,
  output logic [tcw_pkg::CHAR_W-1:0] out_read_char,
  output logic [tcw_pkg::ATTR_W-1:0] out_read_attr,
  output logic                       out_screen_cleared
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0]         LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0]         COLS_A    = ADDR_W'(COLS);
  localparam logic [tcw_pkg::POS_W-1:0] COLS_P    = tcw_pkg::POS_W'(COLS);
  localparam logic [tcw_pkg::COL_W-1:0] COL_MAX   = tcw_pkg::COL_W'(COLS);
  localparam logic [tcw_pkg::ROW_W-1:0] ROW_MAX   = tcw_pkg::ROW_W'(ROWS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                  st_r, st_nxt;
  logic [tcw_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [tcw_pkg::ATTR_W-1:0]  attr_r, attr_nxt;
  logic                        esc_r, esc_nxt;
  logic [ADDR_W-1:0]           cnt_r, cnt_nxt;
  logic [tcw_pkg::ATTR_W-1:0]  blank_r, blank_nxt;
  logic                        sweep_item_r, sweep_item_nxt;
  logic                        pend_wr_r, pend_wr_nxt;
  logic [tcw_pkg::CHAR_W-1:0]  pend_char_r, pend_char_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [tcw_pkg::COL_W-1:0]   out_col_r;
  logic [tcw_pkg::ROW_W-1:0]   out_row_r;
  logic [tcw_pkg::ATTR_W-1:0]  out_attr_r;
  logic [tcw_pkg::CHAR_W-1:0]  out_rc_r;
  logic [tcw_pkg::ATTR_W-1:0]  out_ra_r;
  logic                        out_clr_r;

  logic                        out_free;
  logic                        load;
  logic [tcw_pkg::CHAR_W-1:0]  ld_rc;
  logic [tcw_pkg::ATTR_W-1:0]  ld_ra;
  logic                        ld_clr;

  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  // put char path
  logic                        wrap;
  logic [tcw_pkg::COL_W-1:0]   col_a, col_b, col_c;
  logic [tcw_pkg::ROW_W-1:0]   row_a, row_b;
  logic                        clr;
  logic [ADDR_W-1:0]           put_addr;

  // move and set path
  logic signed [8:0]           mv_col, mv_row;
  logic [tcw_pkg::COL_W-1:0]   mv_col_c, set_col_c;
  logic [tcw_pkg::ROW_W-1:0]   mv_row_c, set_row_c;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_entry.rd_addr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign out_free  = ~out_valid_r | ~out_stall;
  assign init_busy = (st_r == ST_SWEEP) & ~sweep_item_r;

  always_comb begin
    wrap  = q_entry.is_nl || (col_r >= COL_MAX);
    col_a = wrap ? '0 : col_r;
    row_a = (wrap && (row_r < ROW_MAX)) ? row_r + 1'b1 : row_r;
    clr   = (row_a >= ROW_MAX);
    col_b = clr ? '0 : col_a;
    row_b = clr ? '0 : row_a;
    col_c = (!q_entry.is_nl && (col_b < COL_MAX)) ? col_b + 1'b1 : col_b;
    put_addr = ADDR_W'(row_b) * COLS_A + ADDR_W'(col_b);
  end

  always_comb begin
    mv_col = $signed({2'b00, col_r}) + $signed({q_entry.x_value[7], q_entry.x_value});
    mv_row = $signed({4'b0000, row_r}) + $signed({q_entry.y_value[7], q_entry.y_value});
    if (mv_col[8]) begin
      mv_col_c = '0;
    end else if (mv_col > $signed({2'b00, COL_MAX})) begin
      mv_col_c = COL_MAX;
    end else begin
      mv_col_c = mv_col[tcw_pkg::COL_W-1:0];
    end
    if (mv_row[8]) begin
      mv_row_c = '0;
    end else if (mv_row > $signed({4'b0000, ROW_MAX})) begin
      mv_row_c = ROW_MAX;
    end else begin
      mv_row_c = mv_row[tcw_pkg::ROW_W-1:0];
    end
    if (q_entry.x_value[7]) begin
      set_col_c = '0;
    end else if (q_entry.x_value[6:0] > COL_MAX) begin
      set_col_c = COL_MAX;
    end else begin
      set_col_c = q_entry.x_value[6:0];
    end
    if (q_entry.y_value[7]) begin
      set_row_c = '0;
    end else if (q_entry.y_value[6:0] > {2'b00, ROW_MAX}) begin
      set_row_c = ROW_MAX;
    end else begin
      set_row_c = q_entry.y_value[tcw_pkg::ROW_W-1:0];
    end
  end

  always_comb begin
    st_nxt         = st_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    attr_nxt       = attr_r;
    esc_nxt        = esc_r;
    cnt_nxt        = cnt_r;
    blank_nxt      = blank_r;
    sweep_item_nxt = sweep_item_r;
    pend_wr_nxt    = pend_wr_r;
    pend_char_nxt  = pend_char_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    q_pop          = 1'b0;
    load           = 1'b0;
    ld_rc          = '0;
    ld_ra          = '0;
    ld_clr         = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_entry.kind)
            tcw_pkg::K_PUT: begin
              if (esc_r) begin
                esc_nxt = 1'b0;
                unique if (q_entry.is_w) begin
                  attr_nxt = cfg.white;
                end else if (q_entry.is_r) begin
                  attr_nxt = cfg.red;
                end else if (q_entry.is_p) begin
                  attr_nxt = cfg.pink;
                end else begin
                  attr_nxt = attr_r;
                end
                load = 1'b1;
              end else if (q_entry.is_caret) begin
                esc_nxt = 1'b1;
                load    = 1'b1;
              end else begin
                col_nxt = col_c;
                row_nxt = row_b;
                if (clr) begin
                  // screen runs out: wipe first, character lands on the home cell
                  st_nxt         = ST_SWEEP;
                  cnt_nxt        = '0;
                  blank_nxt      = cfg.white;
                  sweep_item_nxt = 1'b1;
                  pend_wr_nxt    = ~q_entry.is_nl;
                  pend_char_nxt  = q_entry.char_code;
                end else begin
                  ram_we    = ~q_entry.is_nl;
                  ram_waddr = put_addr;
                  ram_wdata = {attr_r, q_entry.char_code};
                  load      = 1'b1;
                end
              end
            end
            tcw_pkg::K_SET: begin
              col_nxt = set_col_c;
              row_nxt = set_row_c;
              load    = 1'b1;
            end
            tcw_pkg::K_MOVE: begin
              col_nxt = mv_col_c;
              row_nxt = mv_row_c;
              load    = 1'b1;
            end
            tcw_pkg::K_READ: begin
              if (q_entry.rd_ok) begin
                ram_re = 1'b1;
                st_nxt = ST_READ;
              end else begin
                load = 1'b1;
              end
            end
            tcw_pkg::K_CLEAR: begin
              col_nxt        = '0;
              row_nxt        = '0;
              st_nxt         = ST_SWEEP;
              cnt_nxt        = '0;
              blank_nxt      = cfg.white;
              sweep_item_nxt = 1'b1;
              pend_wr_nxt    = 1'b0;
            end
            tcw_pkg::K_NOP: begin
              load = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          load   = 1'b1;
          ld_rc  = ram_rdata[tcw_pkg::CHAR_W-1:0];
          ld_ra  = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
          st_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = {blank_r, tcw_pkg::CH_SPACE};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_ADDR) begin
          st_nxt = sweep_item_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ram_we    = pend_wr_r;
          ram_waddr = '0;
          ram_wdata = {attr_r, pend_char_r};
          load      = 1'b1;
          ld_clr    = 1'b1;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_SWEEP;
      col_r        <= '0;
      row_r        <= '0;
      attr_r       <= tcw_pkg::ATTR_WHITE_RST;
      esc_r        <= 1'b0;
      cnt_r        <= '0;
      blank_r      <= tcw_pkg::ATTR_WHITE_RST;
      sweep_item_r <= 1'b0;
      pend_wr_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      attr_r       <= attr_nxt;
      esc_r        <= esc_nxt;
      cnt_r        <= cnt_nxt;
      blank_r      <= blank_nxt;
      sweep_item_r <= sweep_item_nxt;
      pend_wr_r    <= pend_wr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_char_r <= pend_char_nxt;
    if (load) begin
      out_col_r  <= col_nxt;
      out_row_r  <= row_nxt;
      out_attr_r <= attr_nxt;
      out_rc_r   <= ld_rc;
      out_ra_r   <= ld_ra;
      out_clr_r  <= ld_clr;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_col     = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_cursor_pos     = tcw_pkg::POS_W'(out_row_r) * COLS_P
                            + tcw_pkg::POS_W'(out_col_r);
  assign out_current_attr   = out_attr_r;
  assign out_read_char      = out_rc_r;
  assign out_read_attr      = out_ra_r;
  assign out_screen_cleared = out_clr_r;

endmodule

// File: design/text_console_writer.sv
// text_console_writer: top level of the text-mode console engine
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back (which holds tcw_ram)
`timescale 1ns / 1ps

// Text-mode console engine with a COLS x ROWS screen store of 16-bit cells
// (attribute in the high byte, character in the low byte). Each input word carries
// one operation: put char, set cursor, move cursor, read cell or clear; every word
// returns exactly one result word with the cursor, the current attribute, the read
// cell and a cleared flag. A front stage decodes words into a two-entry queue; the
// back stage executes them one at a time against the cursor state and the screen
// ram. Put char, set, move, unused codes and reads off the screen load their result
// from the idle state; a read inside the screen does the registered ram read, then
// loads the result from the read state. A clear, or a put char that runs off the
// last row, starts from the idle state, sweeps the whole store one cell per cycle
// (ROWS*COLS cells, 2000 at the defaults), then finishes; words queue behind it.
// After reset the same sweep fills the store with white spaces; in_stall stays high
// during that sweep while config writes are still taken. While a result waits on
// out_stall the back stage holds and the queue takes up to two more words.

module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,

  // config port
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_wdata,

  // input words
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_op,
  input  logic [7:0]                 in_char_code,
  input  logic signed [7:0]          in_x_value,
  input  logic signed [7:0]          in_y_value,

  // result words
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [6:0]                 out_cursor_col,
  output logic [4:0]                 out_cursor_row,
  output logic [11:0]                out_cursor_pos,
  output logic [7:0]                 out_current_attr,
  output logic [7:0]                 out_read_char,
  output logic [7:0]                 out_read_attr,
  output logic                       out_screen_cleared
);

  // attribute registers
  tcw_pkg::attr_cfg_t cfg_r, cfg_nxt;

  // front to queue
  logic              q_push;
  tcw_pkg::q_entry_t q_push_entry;
  logic              q_full;

  // queue to back
  logic              q_pop;
  logic              q_valid;
  tcw_pkg::q_entry_t q_head;

  // back reports its reset sweep so the front holds off new words
  logic              init_busy;

  // index 3 is not a register, writes there are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        tcw_pkg::CFG_WHITE: cfg_nxt.white = cfg_wdata;
        tcw_pkg::CFG_RED:   cfg_nxt.red   = cfg_wdata;
        tcw_pkg::CFG_PINK:  cfg_nxt.pink  = cfg_wdata;
        default:            cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white <= tcw_pkg::ATTR_WHITE_RST;
      cfg_r.red   <= tcw_pkg::ATTR_RED_RST;
      cfg_r.pink  <= tcw_pkg::ATTR_PINK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // decode and classify
  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_char_code (in_char_code),
    .in_x_value   (in_x_value),
    .in_y_value   (in_y_value),
    .init_busy    (init_busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_push_entry)
  );

  // decouples the front from the back
  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  // execution, screen ram and result register
  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_entry            (q_head),
    .q_pop              (q_pop),
    .init_busy          (init_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_pos     (out_cursor_pos),
    .out_current_attr   (out_current_attr),
    .out_read_char      (out_read_char),
    .out_read_attr      (out_read_attr),
    .out_screen_cleared (out_screen_cleared)
  );

endmodule

// File: bench/tb_text_console_writer.sv
// tb_text_console_writer: self-checking bench for the text console writer
// a scoreboard class predicts every result word, plain tasks drive the input and config ports
// depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module tb_text_console_writer;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  // spare operation codes, the block treats them as no-ops
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  // index past the last register, writes there are dropped
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // a clear sweeps the whole store and holds off the input, so allow several sweeps
  localparam int QUIET_LIMIT = 5 * CELLS + 1000;
  localparam int RANDOM_PER_PHASE = 272;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [11:0] pos;
    logic [7:0]  attr;
    logic [7:0]  rchar;
    logic [7:0]  rattr;
    logic        cleared;
  } console_result_t;

  // shadow console: screen cells, cursor, attribute and escape flag, plus the
  // queue of result words still owed by the block
  class console_scoreboard;
    logic [15:0]     cells [CELLS];
    int              col;
    int              row;
    logic [7:0]      attr;
    bit              esc;
    logic [7:0]      white;
    logic [7:0]      red;
    logic [7:0]      pink;
    console_result_t owed [$];
    int              errors;
    int              n_checked;
    int              n_clears;
    int              n_hits;

    function new();
      white = tcw_pkg::ATTR_WHITE_RST;
      red   = tcw_pkg::ATTR_RED_RST;
      pink  = tcw_pkg::ATTR_PINK_RST;
      attr  = tcw_pkg::ATTR_WHITE_RST;
      esc   = 1'b0;
      wipe();
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        tcw_pkg::CFG_WHITE: white = val;
        tcw_pkg::CFG_RED:   red   = val;
        tcw_pkg::CFG_PINK:  pink  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void wipe();
      for (int i = 0; i < CELLS; i++) cells[i] = {white, tcw_pkg::CH_SPACE};
      col = 0;
      row = 0;
    endfunction

    function int clamp(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    // one put-char step, returns 1 when it ran off the last row
    function bit put(logic [7:0] c);
      bit wiped;
      bit nl;
      int idx;
      wiped = 1'b0;
      nl = (c == tcw_pkg::CH_NEWLINE);
      if (esc) begin
        // second byte of a caret escape, consumed either way
        esc = 1'b0;
        if (c == tcw_pkg::CH_W) attr = white;
        else if (c == tcw_pkg::CH_R) attr = red;
        else if (c == tcw_pkg::CH_P) attr = pink;
        return 1'b0;
      end
      if (c == tcw_pkg::CH_CARET) begin
        esc = 1'b1;
        return 1'b0;
      end
      if (nl || col >= COLS) begin
        col = 0;
        if (row < ROWS) row++;
      end
      if (row >= ROWS) begin
        wipe();
        wiped = 1'b1;
      end
      if (!nl) begin
        idx = row * COLS + col;
        if (idx < CELLS) cells[idx] = {attr, c};
        if (col < COLS) col++;
      end
      return wiped;
    endfunction

    function void note_word(logic [2:0] op, logic [7:0] ch,
                            logic signed [7:0] xs, logic signed [7:0] ys);
      console_result_t r;
      int xv;
      int yv;
      logic [15:0] scr_word;
      xv = xs;
      yv = ys;
      r = '0;
      case (op)
        tcw_pkg::OP_PUT: r.cleared = put(ch);
        tcw_pkg::OP_SET: begin
          col = clamp(xv, COLS);
          row = clamp(yv, ROWS);
        end
        tcw_pkg::OP_MOVE: begin
          col = clamp(col + xv, COLS);
          row = clamp(row + yv, ROWS);
        end
        tcw_pkg::OP_READ: begin
          if (xv >= 0 && xv < COLS && yv >= 0 && yv < ROWS) begin
            scr_word = cells[yv * COLS + xv];
            r.rchar = scr_word[7:0];
            r.rattr = scr_word[15:8];
            n_hits++;
          end
        end
        tcw_pkg::OP_CLEAR: begin
          wipe();
          r.cleared = 1'b1;
        end
        default: ;
      endcase
      if (r.cleared) n_clears++;
      r.col  = 7'(col);
      r.row  = 5'(row);
      r.pos  = 12'(row * COLS + col);
      r.attr = attr;
      owed.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task cmp(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s got %0d want %0d", n_checked, name, got, want));
    endtask

    task check_word(console_result_t got);
      console_result_t want;
      if (owed.size() == 0) begin
        report("result word with nothing outstanding");
        return;
      end
      want = owed.pop_front();
      cmp("cursor_col", got.col, want.col);
      cmp("cursor_row", got.row, want.row);
      cmp("cursor_pos", got.pos, want.pos);
      cmp("current_attr", got.attr, want.attr);
      cmp("read_char", got.rchar, want.rchar);
      cmp("read_attr", got.rattr, want.rattr);
      cmp("screen_cleared", got.cleared, want.cleared);
      n_checked++;
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [7:0]        cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_op = '0;
  logic [7:0]        in_char_code = '0;
  logic signed [7:0] in_x_value = '0;
  logic signed [7:0] in_y_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [6:0]        out_cursor_col;
  logic [4:0]        out_cursor_row;
  logic [11:0]       out_cursor_pos;
  logic [7:0]        out_current_attr;
  logic [7:0]        out_read_char;
  logic [7:0]        out_read_attr;
  logic              out_screen_cleared;

  console_scoreboard sb;
  console_result_t   seen;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                n_sent = 0;
  int                quiet = 0;

  always #6 clk = ~clk;

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_char_code      (in_char_code),
    .in_x_value        (in_x_value),
    .in_y_value        (in_y_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_pos    (out_cursor_pos),
    .out_current_attr  (out_current_attr),
    .out_read_char     (out_read_char),
    .out_read_attr     (out_read_attr),
    .out_screen_cleared(out_screen_cleared)
  );

  // result side: values read right after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.col     = out_cursor_col;
      seen.row     = out_cursor_row;
      seen.pos     = out_cursor_pos;
      seen.attr    = out_current_attr;
      seen.rchar   = out_read_char;
      seen.rattr   = out_read_attr;
      seen.cleared = out_screen_cleared;
      sb.check_word(seen);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (rst_n) begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results owed",
                 quiet, sb.pending());
        $display("tb_text_console_writer: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(255));
  endfunction

  // present one word, hold it until taken, then tell the scoreboard
  // entered and left at a rising edge; valid stays high into the next word
  task automatic send_word(input logic [2:0] op, input logic [7:0] ch,
                           input logic signed [7:0] xv, input logic signed [7:0] yv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_char_code <= ch;
    in_x_value   <= xv;
    in_y_value   <= yv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, ch, xv, yv);
    n_sent++;
  endtask

  // unused fields get random bytes so every input bit toggles
  task automatic put_word(input logic [7:0] c);
    send_word(tcw_pkg::OP_PUT, c, rand8(), rand8());
  endtask

  task automatic cursor_word(input logic [2:0] op, input int xv, input int yv);
    send_word(op, rand8(), 8'(xv), 8'(yv));
  endtask

  // hold the input low and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_regs(input logic [7:0] w, input logic [7:0] r,
                            input logic [7:0] p, input logic [7:0] junk);
    cfg_wr_en <= 1'b1;
    cfg_index <= tcw_pkg::CFG_WHITE;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= tcw_pkg::CFG_RED;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_index <= tcw_pkg::CFG_PINK;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(tcw_pkg::CFG_WHITE, w);
    sb.set_reg(tcw_pkg::CFG_RED, r);
    sb.set_reg(tcw_pkg::CFG_PINK, p);
    sb.set_reg(CFG_SPARE, junk);
  endtask

  task automatic directed_words();
    // plain text, the zero byte and the top byte are all ordinary characters
    put_word(8'd65);
    put_word(8'd0);
    put_word(8'd255);
    cursor_word(tcw_pkg::OP_READ, 0, 0);
    // caret escapes: red, a doubled caret, an unknown letter
    put_word(tcw_pkg::CH_CARET);
    put_word(tcw_pkg::CH_R);
    put_word(8'd120);
    put_word(tcw_pkg::CH_CARET);
    put_word(tcw_pkg::CH_CARET);
    put_word(tcw_pkg::CH_CARET);
    put_word(8'd113);
    // escape left pending across a cursor op, then pink
    put_word(tcw_pkg::CH_CARET);
    cursor_word(tcw_pkg::OP_SET, 79, 3);
    put_word(tcw_pkg::CH_P);
    // fill the last column, then the next character wraps onto row 4
    put_word(8'd67);
    put_word(8'd68);
    cursor_word(tcw_pkg::OP_READ, 0, 4);
    put_word(tcw_pkg::CH_NEWLINE);
    // clamping at both ends
    cursor_word(tcw_pkg::OP_SET, -128, -128);
    cursor_word(tcw_pkg::OP_MOVE, 127, -128);
    cursor_word(tcw_pkg::OP_MOVE, -128, 127);
    // cursor parked one row past the end: newline wipes, then a char wipes
    put_word(tcw_pkg::CH_NEWLINE);
    cursor_word(tcw_pkg::OP_SET, 127, 127);
    put_word(8'd66);
    // reads off the screen, unused op codes, explicit clear, back to white
    cursor_word(tcw_pkg::OP_READ, -1, 0);
    cursor_word(tcw_pkg::OP_READ, COLS, ROWS - 1);
    cursor_word(tcw_pkg::OP_READ, COLS - 1, ROWS);
    send_word(OP_SPARE_LO, rand8(), rand8(), rand8());
    send_word(OP_SPARE_HI, rand8(), rand8(), rand8());
    send_word(tcw_pkg::OP_CLEAR, rand8(), rand8(), rand8());
    put_word(tcw_pkg::CH_CARET);
    put_word(tcw_pkg::CH_W);
  endtask

  // one random burst: mostly console traffic a driver would send, some noise
  task automatic random_burst();
    int pick;
    int sub;
    int d;
    pick = $urandom_range(99);
    if (pick < 50) begin
      // printable text, now and then any byte
      if ($urandom_range(9) == 0) put_word(rand8());
      else put_word(8'($urandom_range(126, 32)));
    end else if (pick < 58) begin
      put_word(tcw_pkg::CH_NEWLINE);
    end else if (pick < 66) begin
      // attribute escape, sometimes with another word in between
      put_word(tcw_pkg::CH_CARET);
      if ($urandom_range(5) == 0) cursor_word(tcw_pkg::OP_READ, $urandom_range(COLS - 1),
                                              $urandom_range(ROWS - 1));
      sub = $urandom_range(5);
      case (sub)
        0: put_word(tcw_pkg::CH_W);
        1: put_word(tcw_pkg::CH_R);
        2: put_word(tcw_pkg::CH_P);
        3: put_word(tcw_pkg::CH_CARET);
        4: put_word(tcw_pkg::CH_NEWLINE);
        default: put_word(rand8());
      endcase
    end else if (pick < 73) begin
      sub = $urandom_range(9);
      if (sub < 4)
        cursor_word(tcw_pkg::OP_SET, $urandom_range(COLS - 1), $urandom_range(ROWS - 1));
      else if (sub < 7)
        cursor_word(tcw_pkg::OP_SET, COLS - $urandom_range(1), ROWS - $urandom_range(1));
      else
        send_word(tcw_pkg::OP_SET, rand8(), rand8(), rand8());
    end else if (pick < 79) begin
      if ($urandom_range(9) < 7) begin
        d = $urandom_range(6);
        sub = $urandom_range(6);
        cursor_word(tcw_pkg::OP_MOVE, d - 3, sub - 3);
      end else begin
        send_word(tcw_pkg::OP_MOVE, rand8(), rand8(), rand8());
      end
    end else if (pick < 93) begin
      sub = $urandom_range(9);
      if (sub < 6)
        // the cell just written
        cursor_word(tcw_pkg::OP_READ, (sb.col > 0) ? sb.col - 1 : 0,
                    (sb.row < ROWS) ? sb.row : ROWS - 1);
      else if (sub < 9)
        cursor_word(tcw_pkg::OP_READ, $urandom_range(COLS - 1), $urandom_range(ROWS - 1));
      else
        send_word(tcw_pkg::OP_READ, rand8(), rand8(), rand8());
    end else if (pick < 94) begin
      send_word(tcw_pkg::OP_CLEAR, rand8(), rand8(), rand8());
    end else begin
      // noise: any op code with any payload
      send_word(3'($urandom_range(7)), rand8(), rand8(), rand8());
    end
  endtask

  task automatic random_phase(input int s_pct, input int r_pct);
    int stop_at;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = n_sent + RANDOM_PER_PHASE;
    while (n_sent < stop_at) random_burst();
    drain();
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed words against the reset register values
    send_idle_pct = 12;
    recv_idle_pct = 59;
    directed_words();
    drain();

    // extremes of the attribute registers
    write_regs(8'h00, 8'hFF, 8'h00, 8'hA5);
    random_phase(12, 59);

    write_regs(8'hFF, 8'h00, 8'hFF, 8'h5A);
    random_phase(59, 12);

    write_regs(rand8(), rand8(), rand8(), rand8());
    random_phase(0, 0);

    // catch any stray result after the last one owed
    repeat (64) @(posedge clk);

    $display("summary: %0d words sent, %0d results checked over three stall patterns",
             n_sent, sb.n_checked);
    $display("summary: %0d screen clears, %0d reads inside the screen, four register sets",
             sb.n_clears, sb.n_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_text_console_writer: done, clean");
    end else begin
      $display("%0d mismatches, %0d results still owed", sb.errors, sb.pending());
      $display("tb_text_console_writer: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_front.sv
design/tcw_queue.sv
design/tcw_back.sv
design/text_console_writer.sv
bench/tb_text_console_writer.sv
